### hdl/bitap_mismatch_search_top_assert.svh
// Assertion macros shared by the bitap mismatch search modules.
// Each macro expands to one labeled concurrent assertion that is
// clocked on the rising edge and disabled while reset is active.
`ifndef BITAP_MISMATCH_SEARCH_TOP_ASSERT_SVH
`define BITAP_MISMATCH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BMS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define BMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Shared codes, widths and types of the bitap mismatch search block.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int FUNC_W   = 2;
    localparam int SYM_W    = 7;
    localparam int CFG_W    = 3;
    localparam int SCORE_W  = 17;
    localparam int STATUS_W = 2;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEXT   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd3;

    localparam logic [SCORE_W-1:0] SCORE_NONE = '1;
    localparam logic [SCORE_W-1:0] SCORE_CAP  = 17'd65535;

    // Depth of the queue between the front and back parts.
    localparam int Q_DEPTH = 2;

    // Work orders the front hands to the back.
    typedef enum logic [2:0] {
        OP_REWIND,
        OP_TEXT,
        OP_END_EMPTY,
        OP_END_LONG,
        OP_END_SEARCH
    } bms_op_t;

    localparam int OP_W = $bits(bms_op_t);

endpackage

### hdl/bms_front.sv
// ----------------------------------------------------------------------------
// bms_front
// Accepts items, keeps the pattern masks and length, and classifies items.
// ----------------------------------------------------------------------------
module bms_front import bms_pkg::*; #(
    parameter int MAX_PATTERN = 31,
    parameter int ALPHABET    = 128,
    localparam int LEN_W      = $clog2(MAX_PATTERN + 2)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FUNC_W-1:0]      s_func,
    input  logic [SYM_W-1:0]       s_symbol,
    output logic                   f_valid,
    input  logic                   f_take,
    output bms_op_t                f_op,
    output logic [LEN_W-1:0]       f_plen,
    output logic [MAX_PATTERN-1:0] f_mask
);

    localparam int ADDR_W = $clog2(ALPHABET);
    localparam int BIT_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0] mask_mem [ALPHABET];

    logic                   f_valid_reg, f_valid_next;
    bms_op_t                f_op_reg;
    logic [LEN_W-1:0]       f_plen_reg;
    logic                   hit_reg;
    logic [MAX_PATTERN-1:0] rd_data_reg;
    logic [LEN_W-1:0]       plen_reg, plen_next;
    logic [ALPHABET-1:0]    valid_reg, valid_next;

    logic              accept;
    logic              sym_in;
    logic [ADDR_W-1:0] idx;
    logic              len_ok;
    logic              room;
    logic              need_back;
    bms_op_t           op_class;
    logic              mem_wr;
    logic              mem_rd;

    assign s_ready = !f_valid_reg || f_take;
    assign accept  = s_valid && s_ready;
    assign sym_in  = 32'(s_symbol) < ALPHABET;
    assign idx     = ADDR_W'(s_symbol);
    assign len_ok  = (plen_reg != '0) && (32'(plen_reg) <= MAX_PATTERN);
    assign room    = 32'(plen_reg) < MAX_PATTERN;
    assign mem_wr  = accept && (s_func == FUNC_APPEND) && room && sym_in;
    assign mem_rd  = accept && (s_func == FUNC_TEXT) && sym_in;

    always_comb begin
        need_back = 1'b0;
        op_class  = OP_REWIND;
        unique case (s_func)
            FUNC_CLEAR: begin
                need_back = 1'b1;
                op_class  = OP_REWIND;
            end
            FUNC_APPEND: begin
                need_back = 1'b0;
            end
            FUNC_TEXT: begin
                need_back = len_ok;
                op_class  = OP_TEXT;
            end
            FUNC_END: begin
                need_back = 1'b1;
                if (plen_reg == '0) begin
                    op_class = OP_END_EMPTY;
                end else if (!len_ok) begin
                    op_class = OP_END_LONG;
                end else begin
                    op_class = OP_END_SEARCH;
                end
            end
            default: begin
                need_back = 1'b0;
            end
        endcase
    end

    always_comb begin
        plen_next    = plen_reg;
        valid_next   = valid_reg;
        f_valid_next = f_valid_reg;
        if (f_take) begin
            f_valid_next = 1'b0;
        end
        if (accept) begin
            f_valid_next = need_back;
            if (s_func == FUNC_CLEAR) begin
                plen_next  = '0;
                valid_next = '0;
            end else if (s_func == FUNC_APPEND) begin
                if (room) begin
                    plen_next = plen_reg + LEN_W'(1);
                    if (sym_in) begin
                        valid_next[idx] = 1'b1;
                    end
                end else begin
                    plen_next = LEN_W'(MAX_PATTERN + 1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            plen_reg    <= '0;
            valid_reg   <= '0;
        end else begin
            f_valid_reg <= f_valid_next;
            plen_reg    <= plen_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_op_reg   <= op_class;
            f_plen_reg <= plen_reg;
            hit_reg    <= sym_in && valid_reg[idx];
        end
    end

    // A never-written entry is rewritten whole; otherwise one bit is cleared.
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            if (valid_reg[idx]) begin
                mask_mem[idx][plen_reg[BIT_W-1:0]] <= 1'b0;
            end else begin
                mask_mem[idx] <= ~(MAX_PATTERN'(1) << plen_reg);
            end
        end
        if (mem_rd) begin
            rd_data_reg <= mask_mem[idx];
        end
    end

    assign f_valid = f_valid_reg;
    assign f_op    = f_op_reg;
    assign f_plen  = f_plen_reg;
    assign f_mask  = hit_reg ? rd_data_reg : '1;

endmodule

### hdl/bms_queue.sv
// ----------------------------------------------------------------------------
// bms_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module bms_queue import bms_pkg::*; #(
    parameter int DATA_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              full,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CNT_W'(Q_DEPTH);
    assign pop_valid = count_reg != '0;
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/bms_back.sv
// ----------------------------------------------------------------------------
// bms_back
// Runs the error rows over text, latches the first match, drives results.
// ----------------------------------------------------------------------------
module bms_back import bms_pkg::*; #(
    parameter int MAX_ERRORS  = 7,
    parameter int MAX_PATTERN = 31,
    parameter int POS_WIDTH   = 16,
    localparam int LEN_W      = $clog2(MAX_PATTERN + 2)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  bms_op_t                q_op,
    input  logic [LEN_W-1:0]       q_plen,
    input  logic [MAX_PATTERN-1:0] q_mask,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SCORE_W-1:0]     m_score,
    output logic [STATUS_W-1:0]    m_status
);

    `include "bitap_mismatch_search_top_assert.svh"

    localparam int ROWS   = MAX_ERRORS + 1;
    localparam int ROW_W  = MAX_PATTERN + 1;
    localparam int LVL_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PIDX_W = $clog2(ROW_W);
    localparam logic [ROW_W-1:0] ROW_INIT = ~ROW_W'(1);

    logic [ROW_W-1:0]     rows_reg [ROWS];
    logic [ROW_W-1:0]     rows_next [ROWS];
    logic [ROW_W-1:0]     rows_step [ROWS];
    logic [POS_WIDTH-1:0] text_pos_reg, text_pos_next;
    logic                 match_found_reg, match_found_next;
    logic [POS_WIDTH-1:0] match_start_reg, match_start_next;
    logic [CFG_W-1:0]     max_err_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0]   m_score_reg, m_score_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;

    logic                 is_end;
    logic [ROW_W-1:0]     sym_mask;
    logic [LVL_W-1:0]     lvl;
    logic                 hit;
    logic [POS_WIDTH:0]   pos_inc;
    logic [POS_WIDTH:0]   plen_ext;
    logic [32:0]          start_ext;

    assign is_end = (q_op == OP_END_EMPTY) || (q_op == OP_END_LONG) || (q_op == OP_END_SEARCH);
    assign q_pop  = q_valid && (!is_end || !m_valid_reg || m_ready);

    assign sym_mask = {1'b1, q_mask};
    assign lvl = (32'(max_err_reg) > MAX_ERRORS) ? LVL_W'(MAX_ERRORS) : LVL_W'(max_err_reg);

    // Row d steps from its old value and, for d > 0, the old value of row d-1.
    always_comb begin
        logic [ROW_W-1:0] ored;
        for (int d = 0; d < ROWS; d++) begin
            ored = rows_reg[d] | sym_mask;
            if (d > 0) begin
                ored = ored & rows_reg[d-1];
            end
            rows_step[d] = {ored[ROW_W-2:0], 1'b0};
        end
    end

    assign hit       = !rows_step[lvl][q_plen[PIDX_W-1:0]];
    assign pos_inc   = {1'b0, text_pos_reg} + (POS_WIDTH+1)'(1);
    assign plen_ext  = (POS_WIDTH+1)'(q_plen);
    assign start_ext = 33'(match_start_reg);

    always_comb begin
        rows_next        = rows_reg;
        text_pos_next    = text_pos_reg;
        match_found_next = match_found_reg;
        match_start_next = match_start_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_score_next     = m_score_reg;
        m_status_next    = m_status_reg;
        if (q_pop) begin
            if (q_op == OP_TEXT) begin
                if (!match_found_reg) begin
                    rows_next = rows_step;
                    if (hit) begin
                        match_found_next = 1'b1;
                        match_start_next = (pos_inc >= plen_ext) ?
                                           POS_WIDTH'(pos_inc - plen_ext) : '0;
                    end
                    if (text_pos_reg != '1) begin
                        text_pos_next = text_pos_reg + POS_WIDTH'(1);
                    end
                end
            end else begin
                for (int d = 0; d < ROWS; d++) begin
                    rows_next[d] = ROW_INIT;
                end
                text_pos_next    = '0;
                match_found_next = 1'b0;
                match_start_next = '0;
            end
            if (is_end) begin
                m_valid_next = 1'b1;
                if (q_op == OP_END_EMPTY) begin
                    m_score_next  = '0;
                    m_status_next = STATUS_EMPTY;
                end else if (q_op == OP_END_LONG) begin
                    m_score_next  = SCORE_NONE;
                    m_status_next = STATUS_TOO_LONG;
                end else if (match_found_reg) begin
                    m_score_next  = (start_ext > 33'(SCORE_CAP)) ? SCORE_CAP :
                                    SCORE_W'(start_ext);
                    m_status_next = STATUS_MATCH;
                end else begin
                    m_score_next  = SCORE_NONE;
                    m_status_next = STATUS_NO_MATCH;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < ROWS; d++) begin
                rows_reg[d] <= ROW_INIT;
            end
            text_pos_reg    <= '0;
            match_found_reg <= 1'b0;
            match_start_reg <= '0;
            max_err_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            rows_reg        <= rows_next;
            text_pos_reg    <= text_pos_next;
            match_found_reg <= match_found_next;
            match_start_reg <= match_start_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                max_err_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_score_reg  <= m_score_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_score  = m_score_reg;
    assign m_status = m_status_reg;

    `BMS_ASSERT_NEXT(a_match_latched, aclk, aresetn, match_found_reg && !(q_pop && (q_op != OP_TEXT)), match_found_reg && $stable(match_start_reg), "match latch changed without a rewind")
    `BMS_ASSERT_IMPLIES(a_match_score_positive, aclk, aresetn, m_valid_reg && (m_status_reg == STATUS_MATCH), !m_score_reg[SCORE_W-1], "match result carries a negative score")
    `BMS_ASSERT_IMPLIES(a_fail_score_none, aclk, aresetn, m_valid_reg && ((m_status_reg == STATUS_NO_MATCH) || (m_status_reg == STATUS_TOO_LONG)), m_score_reg == SCORE_NONE, "failed search does not report minus one")

endmodule

### hdl/bitap_mismatch_search_top.sv
// ----------------------------------------------------------------------------
// bitap_mismatch_search_top
// Shift-or substring search that tolerates a configured number of mismatches.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ channel (s_func, s_symbol) with valid/ready.
// A clear item empties the pattern, append items load it one symbol at a
// time, text items stream the text and an end item returns one result on
// the m_ channel (m_score, m_status) and rewinds the search.
// One item per cycle is accepted unless stalled; only end items give results.
// An accepted end item is first loaded into the front register, then moves
// into the queue and from there into the output register that drives m_valid.
// The per-cycle rate is set by the single port of the mask memory and by the
// row update in the back, which steps all error rows for each popped item.
// cfg_wr_en/cfg_wr_data write max_errors at once; write only while idle.
// Reset is synchronous and active low: the mask memory is invalidated
// through per-symbol valid bits, so no clearing pass is needed. When the
// receiver stalls, the result waits in the output register and a later end
// item waits at the head of the queue; the queue and the front register then
// hold up to three items before s_ready drops.
// ----------------------------------------------------------------------------
module bitap_mismatch_search_top import bms_pkg::*; #(
    parameter int MAX_ERRORS  = 7,
    parameter int MAX_PATTERN = 31,
    parameter int ALPHABET    = 128,
    parameter int POS_WIDTH   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [SYM_W-1:0]    s_symbol,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SCORE_W-1:0]  m_score,
    output logic [STATUS_W-1:0] m_status
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 2);
    localparam int DATA_W = OP_W + LEN_W + MAX_PATTERN;

    // Front part outputs: one classified item waiting to enter the queue.
    logic                   f_valid;
    logic                   f_take;
    bms_op_t                f_op;
    logic [LEN_W-1:0]       f_plen;
    logic [MAX_PATTERN-1:0] f_mask;

    // Queue side.
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [DATA_W-1:0]      q_wdata;
    logic [DATA_W-1:0]      q_rdata;
    bms_op_t                q_op;
    logic [LEN_W-1:0]       q_plen;
    logic [MAX_PATTERN-1:0] q_mask;

    // The front accepts and classifies items and owns the pattern masks.
    bms_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_symbol (s_symbol),
        .f_valid  (f_valid),
        .f_take   (f_take),
        .f_op     (f_op),
        .f_plen   (f_plen),
        .f_mask   (f_mask)
    );

    // An item leaves the front register whenever the queue has room.
    assign f_take  = f_valid && !q_full;
    assign q_wdata = {f_op, f_plen, f_mask};

    bms_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .full       (q_full),
        .push_data  (q_wdata),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_rdata)
    );

    assign q_op   = bms_op_t'(q_rdata[DATA_W-1 -: OP_W]);
    assign q_plen = q_rdata[MAX_PATTERN +: LEN_W];
    assign q_mask = q_rdata[MAX_PATTERN-1:0];

    // The back part runs the search and holds the result register.
    bms_back #(
        .MAX_ERRORS  (MAX_ERRORS),
        .MAX_PATTERN (MAX_PATTERN),
        .POS_WIDTH   (POS_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_op        (q_op),
        .q_plen      (q_plen),
        .q_mask      (q_mask),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_score     (m_score),
        .m_status    (m_status)
    );

endmodule
